// ===== rtl/core/qsu_pkg.sv =====
package qsu_pkg;

    // parser phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_BODY    = 3'd1;
    localparam logic [2:0] PH_ESC     = 3'd2;
    localparam logic [2:0] PH_HEX     = 3'd3;
    localparam logic [2:0] PH_LOW_BS  = 3'd4;
    localparam logic [2:0] PH_LOW_U   = 3'd5;
    localparam logic [2:0] PH_LOW_HEX = 3'd6;
    localparam logic [2:0] PH_PEND    = 3'd7;

    // status codes carried with each result word
    localparam logic [2:0] ST_OPEN          = 3'd0;
    localparam logic [2:0] ST_CLOSED        = 3'd1;
    localparam logic [2:0] ST_CLOSED_BEFORE = 3'd2;
    localparam logic [2:0] ST_INVALID       = 3'd3;
    localparam logic [2:0] ST_UNTERM        = 3'd4;

    typedef struct packed {
        logic [2:0]  phase;
        logic        quote_is_double;
        logic        strict_json;
        logic [15:0] hex_accum;
        logic [1:0]  hex_digits_seen;
        logic [9:0]  high_surrogate;
    } t_state;

    // all result words caused by one input word
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic            byte_valid;
        logic [2:0]      first_status;
        logic [2:0]      rest_status;
        logic [1:0]      cnt_m1;
    } t_bundle;

endpackage

// ===== rtl/core/qsu_in_if.sv =====
interface qsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_of_string;
    logic       json_rules;
    logic       end_of_range;

    modport source (
        output valid, in_byte, start_of_string, json_rules, end_of_range,
        input  ready
    );
    modport sink (
        input  valid, in_byte, start_of_string, json_rules, end_of_range,
        output ready
    );
endinterface

// ===== rtl/core/qsu_out_if.sv =====
interface qsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;

    modport source (
        output valid, out_byte, byte_valid, status, last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, byte_valid, status, last,
        output ready
    );
endinterface

// ===== rtl/core/qsu_decode.sv =====
module qsu_decode (
    input  qsu_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_start,
    input  logic             i_json,
    input  logic             i_eor,
    output qsu_pkg::t_state  o_state,
    output qsu_pkg::t_bundle o_bundle,
    output logic             o_emit
);
    import qsu_pkg::*;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } t_utf8;

    // {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic t_utf8 utf8(input logic [20:0] cp);
        t_utf8 u;
        u = '0;
        if (cp < 21'h80) begin
            u.n = 3'd1; u.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            u.n = 3'd2; u.b[0] = {3'b110, cp[10:6]}; u.b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            u.n = 3'd3; u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]}; u.b[2] = {2'b10, cp[5:0]};
        end else begin
            u.n = 3'd4; u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]}; u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    logic [4:0]  w_hex;
    logic [15:0] w_acc;
    logic        w_full_unit;
    logic        w_is_high;
    logic        w_is_low;
    logic [20:0] w_cp;
    t_utf8       w_enc;
    t_state      n_st;
    logic [2:0]  st;
    logic [2:0]  nb;
    logic [3:0][7:0] bytes;
    logic        pre;
    logic [2:0]  pre_st;
    logic        emit;
    logic [7:0]  quote;

    assign w_hex       = hex_digit(i_byte);
    assign w_acc       = {i_state.hex_accum[11:0], w_hex[3:0]};
    assign w_full_unit = (i_state.hex_digits_seen == 2'd3);
    assign w_is_high   = (w_acc[15:10] == 6'b110110);
    assign w_is_low    = (w_acc[15:10] == 6'b110111);
    // pair gives 0x10000 + (high << 10) + low offset
    assign w_cp = (i_state.phase == PH_LOW_HEX)
                ? ({1'b0, i_state.high_surrogate, w_acc[9:0]} + CP_SUPP_BASE)
                : {5'd0, w_acc};
    assign w_enc = utf8(w_cp);
    assign quote = i_state.quote_is_double ? CH_DQUOTE : CH_SQUOTE;

    always_comb begin
        n_st   = i_state;
        st     = ST_OPEN;
        nb     = 3'd0;
        bytes  = '0;
        pre    = 1'b0;
        pre_st = ST_OPEN;
        emit   = 1'b1;
        if (i_start) begin
            if (i_state.phase != PH_IDLE) begin
                pre    = 1'b1;
                pre_st = (i_state.phase == PH_PEND) ? ST_CLOSED_BEFORE : ST_UNTERM;
            end
            n_st.phase           = PH_IDLE;
            n_st.strict_json     = i_json;
            n_st.hex_accum       = '0;
            n_st.hex_digits_seen = '0;
            n_st.high_surrogate  = '0;
            if (i_byte == CH_DQUOTE || (i_byte == CH_SQUOTE && !i_json)) begin
                n_st.quote_is_double = (i_byte == CH_DQUOTE);
                n_st.phase = i_eor ? PH_IDLE : PH_BODY;
                st = i_eor ? ST_UNTERM : ST_OPEN;
            end else begin
                st = ST_INVALID;
            end
        end else if (i_state.phase == PH_IDLE) begin
            emit = 1'b0;
        end else begin
            unique case (i_state.phase)
                PH_BODY: begin
                    if (i_byte == quote) begin
                        if (i_state.quote_is_double) begin
                            st = ST_CLOSED; n_st.phase = PH_IDLE;
                        end else begin
                            n_st.phase = PH_PEND;
                        end
                    end else if (i_state.quote_is_double && i_byte == CH_BSLASH) begin
                        n_st.phase = PH_ESC;
                    end else if (i_byte < CH_SPACE
                                 && (i_state.strict_json || i_byte != CH_TAB)) begin
                        st = ST_INVALID;
                    end else begin
                        nb = 3'd1; bytes[0] = i_byte;
                    end
                end
                PH_PEND: begin
                    if (i_byte == CH_SQUOTE) begin
                        nb = 3'd1; bytes[0] = i_byte; n_st.phase = PH_BODY;
                    end else begin
                        st = ST_CLOSED_BEFORE; n_st.phase = PH_IDLE;
                    end
                end
                PH_ESC: begin
                    n_st.phase = PH_BODY;
                    nb = 3'd1;
                    case (i_byte)
                        CH_B: bytes[0] = 8'h08;
                        CH_T: bytes[0] = 8'h09;
                        CH_N: bytes[0] = 8'h0A;
                        CH_F: bytes[0] = 8'h0C;
                        CH_R: bytes[0] = 8'h0D;
                        CH_DQUOTE, CH_SLASH, CH_BSLASH: bytes[0] = i_byte;
                        CH_U: begin
                            nb = 3'd0;
                            n_st.phase = PH_HEX;
                            n_st.hex_accum = '0;
                            n_st.hex_digits_seen = '0;
                        end
                        default: begin
                            nb = 3'd0; st = ST_INVALID;
                        end
                    endcase
                end
                PH_HEX, PH_LOW_HEX: begin
                    if (!w_hex[4]) begin
                        st = ST_INVALID;
                    end else begin
                        n_st.hex_accum = w_acc;
                        if (!w_full_unit) begin
                            n_st.hex_digits_seen = i_state.hex_digits_seen + 2'd1;
                        end else begin
                            n_st.hex_digits_seen = 2'd0;
                            if (i_state.phase == PH_HEX) begin
                                if (w_is_high) begin
                                    n_st.high_surrogate = w_acc[9:0];
                                    n_st.phase = PH_LOW_BS;
                                end else if (w_is_low) begin
                                    st = ST_INVALID;
                                end else begin
                                    nb = w_enc.n; bytes = w_enc.b;
                                    n_st.phase = PH_BODY;
                                end
                            end else if (w_is_low) begin
                                nb = w_enc.n; bytes = w_enc.b;
                                n_st.phase = PH_BODY;
                            end else begin
                                st = ST_INVALID;
                            end
                        end
                    end
                end
                PH_LOW_BS: begin
                    if (i_byte == CH_BSLASH) n_st.phase = PH_LOW_U;
                    else st = ST_INVALID;
                end
                PH_LOW_U: begin
                    if (i_byte == CH_U) begin
                        n_st.phase = PH_LOW_HEX;
                        n_st.hex_accum = '0;
                        n_st.hex_digits_seen = '0;
                    end else begin
                        st = ST_INVALID;
                    end
                end
                default: begin
                    n_st.phase = PH_IDLE;
                    emit = 1'b0;
                end
            endcase
            if (st == ST_INVALID) begin
                nb = 3'd0;
                n_st.phase = PH_IDLE;
            end else if (st == ST_OPEN && i_eor) begin
                st = (n_st.phase == PH_PEND) ? ST_CLOSED : ST_UNTERM;
                n_st.phase = PH_IDLE;
            end
        end
    end

    always_comb begin
        o_state = n_st;
        o_emit  = emit;
        o_bundle.bytes = bytes;
        if (nb != 3'd0) begin
            o_bundle.byte_valid   = 1'b1;
            o_bundle.first_status = st;
            o_bundle.rest_status  = st;
            o_bundle.cnt_m1       = 2'(nb - 3'd1);
        end else begin
            o_bundle.byte_valid   = 1'b0;
            o_bundle.first_status = pre ? pre_st : st;
            o_bundle.rest_status  = st;
            o_bundle.cnt_m1       = {1'b0, pre};
        end
    end

endmodule

// ===== rtl/core/quoted_string_unescape_top.sv =====
// Output: each input word's first result word is valid in the cycle after it is accepted.
// Throughput: one input word per cycle while each yields at most one result word and the
// output is ready; a word with n result words (up to four) holds the register until all leave.
// Reset (i_rst_n low, synchronous): parser goes idle, escape state clears, output empties.
module quoted_string_unescape_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qsu_in_if.sink    i_in,
    qsu_out_if.source o_out
);
    import qsu_pkg::*;

    // Parser state, updated on every accepted input word.
    t_state  r_state;
    t_state  n_state;

    // Result register: every result word of one input word, walked out one per cycle while ready.
    t_bundle r_bundle;
    t_bundle n_bundle;
    logic    r_full;
    logic [1:0] r_idx;

    logic w_emit;
    logic w_accept;
    logic w_out_last;
    logic w_pop;

    qsu_decode u_decode (
        .i_state  (r_state),
        .i_byte   (i_in.in_byte),
        .i_start  (i_in.start_of_string),
        .i_json   (i_in.json_rules),
        .i_eor    (i_in.end_of_range),
        .o_state  (n_state),
        .o_bundle (n_bundle),
        .o_emit   (w_emit)
    );

    assign w_out_last = (r_idx == r_bundle.cnt_m1);
    assign w_pop      = r_full && o_out.ready;

    // Take a new word when the result register is empty or its final word leaves now.
    assign i_in.ready = !r_full || (o_out.ready && w_out_last);
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_full  <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
            end
            if (w_accept && w_emit) begin
                r_full <= 1'b1;
                r_idx  <= 2'd0;
            end else if (w_pop) begin
                if (w_out_last) begin
                    // drop the drained bundle
                    r_full <= 1'b0;
                end else begin
                    // advance to the next result word
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    // Payload holds without reset; only loaded on a producing accept.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_bundle <= n_bundle;
        end
    end

    assign o_out.valid      = r_full;
    assign o_out.byte_valid = r_bundle.byte_valid;
    assign o_out.out_byte   = r_bundle.byte_valid ? r_bundle.bytes[r_idx] : 8'd0;
    assign o_out.status     = (r_idx == 2'd0) ? r_bundle.first_status
                                              : r_bundle.rest_status;
    assign o_out.last       = w_out_last;

    // A bundle without decoded bytes holds at most the ended-string word and one more.
    a_nobyte_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !r_bundle.byte_valid) |-> (r_bundle.cnt_m1 <= 2'd1))
        else $error("byte-less bundle longer than two words");

    // A taken word that is not the last moves the read index by exactly one.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last)
        |=> (o_out.valid && r_idx == $past(r_idx) + 2'd1))
        else $error("result index did not advance");

    // Status stays within the defined codes.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status <= ST_UNTERM))
        else $error("status code out of range");

endmodule

// ===== sim/qsu_unescape_checker.sv =====
module qsu_unescape_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    qsu_in_if    i_in,
    qsu_out_if   i_out,
    output int   o_fail_count,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import qsu_pkg::*;

    localparam logic [7:0]  CH_DQUOTE  = 8'h22;
    localparam logic [7:0]  CH_SQUOTE  = 8'h27;
    localparam logic [7:0]  CH_BSLASH  = 8'h5c;
    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CTRL_LIMIT = 8'h20;
    localparam logic [15:0] HI_SUR_MIN = 16'hd800;
    localparam logic [15:0] HI_SUR_MAX = 16'hdbff;
    localparam logic [15:0] LO_SUR_MIN = 16'hdc00;
    localparam logic [15:0] LO_SUR_MAX = 16'hdfff;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam int          MAX_SHOWN  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic [2:0] status;
        logic       last;
    } t_decoded_word;

    // parser state mirrored from the block
    logic [2:0]  parse_phase;
    logic        in_double;
    logic        json_mode;
    logic [15:0] hex_word;
    logic [1:0]  hex_count;
    logic [9:0]  high_half;

    t_decoded_word expected_words[$];
    int            mismatches = 0;

    function automatic void queue_word(input logic [7:0] b, input logic v,
                                       input logic [2:0] st, input logic lst);
        expected_words.push_back({b, v, st, lst});
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic int utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] b);
        b = '0;
        if (cp < 21'h80) begin
            b[0] = cp[7:0];
            return 1;
        end
        if (cp < 21'h800) begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 21'h10000) begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
            return 3;
        end
        b[0] = {5'b11110, cp[20:18]};
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    // advance the mirrored parser by one source byte and queue its results
    function automatic void decode_word(input logic [7:0] c, input logic sos,
                                        input logic js, input logic eor);
        logic [3:0][7:0] seq;
        int              n_bytes;
        int              digit;
        int              k;
        logic [2:0]      st;
        logic [20:0]     cp;
        seq     = '0;
        n_bytes = 0;
        st      = ST_OPEN;
        cp      = '0;
        if (sos) begin
            if (parse_phase != PH_IDLE) begin
                queue_word(8'h00, 1'b0,
                           (parse_phase == PH_PEND) ? ST_CLOSED_BEFORE : ST_UNTERM, 1'b0);
                parse_phase = PH_IDLE;
            end
            json_mode = js;
            hex_word  = '0;
            hex_count = '0;
            high_half = '0;
            if (c == CH_DQUOTE || (c == CH_SQUOTE && !js)) begin
                in_double   = (c == CH_DQUOTE);
                parse_phase = eor ? PH_IDLE : PH_BODY;
                st          = eor ? ST_UNTERM : ST_OPEN;
            end else begin
                st = ST_INVALID;
            end
            queue_word(8'h00, 1'b0, st, 1'b1);
            return;
        end
        if (parse_phase == PH_IDLE) return;

        case (parse_phase)
            PH_BODY: begin
                if (c == (in_double ? CH_DQUOTE : CH_SQUOTE)) begin
                    if (in_double) begin
                        st          = ST_CLOSED;
                        parse_phase = PH_IDLE;
                    end else begin
                        parse_phase = PH_PEND;
                    end
                end else if (in_double && c == CH_BSLASH) begin
                    parse_phase = PH_ESC;
                end else if (c < CTRL_LIMIT && (json_mode || c != CH_TAB)) begin
                    st = ST_INVALID;
                end else begin
                    seq[0]  = c;
                    n_bytes = 1;
                end
            end
            PH_PEND: begin
                if (c == CH_SQUOTE) begin
                    seq[0]      = c;
                    n_bytes     = 1;
                    parse_phase = PH_BODY;
                end else begin
                    st          = ST_CLOSED_BEFORE;
                    parse_phase = PH_IDLE;
                end
            end
            PH_ESC: begin
                parse_phase = PH_BODY;
                n_bytes     = 1;
                case (c)
                    "b": seq[0] = 8'h08;
                    "t": seq[0] = 8'h09;
                    "n": seq[0] = 8'h0a;
                    "f": seq[0] = 8'h0c;
                    "r": seq[0] = 8'h0d;
                    CH_DQUOTE, "/", CH_BSLASH: seq[0] = c;
                    "u": begin
                        n_bytes     = 0;
                        parse_phase = PH_HEX;
                        hex_word    = '0;
                        hex_count   = '0;
                    end
                    default: begin
                        n_bytes = 0;
                        st      = ST_INVALID;
                    end
                endcase
            end
            PH_HEX, PH_LOW_HEX: begin
                digit = hex_value(c);
                if (digit < 0) begin
                    st = ST_INVALID;
                end else begin
                    hex_word = {hex_word[11:0], digit[3:0]};
                    if (hex_count < 2'd3) begin
                        hex_count++;
                    end else begin
                        hex_count = '0;
                        if (parse_phase == PH_HEX) begin
                            if (hex_word >= HI_SUR_MIN && hex_word <= HI_SUR_MAX) begin
                                high_half   = hex_word[9:0];
                                parse_phase = PH_LOW_BS;
                            end else if (hex_word >= LO_SUR_MIN && hex_word <= LO_SUR_MAX) begin
                                st = ST_INVALID;
                            end else begin
                                cp          = {5'd0, hex_word};
                                n_bytes     = utf8_encode(cp, seq);
                                parse_phase = PH_BODY;
                            end
                        end else if (hex_word >= LO_SUR_MIN && hex_word <= LO_SUR_MAX) begin
                            cp          = SUPP_BASE + {1'b0, high_half, hex_word[9:0]};
                            n_bytes     = utf8_encode(cp, seq);
                            parse_phase = PH_BODY;
                        end else begin
                            st = ST_INVALID;
                        end
                    end
                end
            end
            PH_LOW_BS: begin
                if (c == CH_BSLASH) parse_phase = PH_LOW_U;
                else st = ST_INVALID;
            end
            PH_LOW_U: begin
                if (c == "u") begin
                    parse_phase = PH_LOW_HEX;
                    hex_word    = '0;
                    hex_count   = '0;
                end else begin
                    st = ST_INVALID;
                end
            end
            default: begin
                parse_phase = PH_IDLE;
                return;
            end
        endcase

        if (st == ST_INVALID) begin
            n_bytes     = 0;
            parse_phase = PH_IDLE;
        end else if (st == ST_OPEN && eor) begin
            st          = (parse_phase == PH_PEND) ? ST_CLOSED : ST_UNTERM;
            parse_phase = PH_IDLE;
        end

        if (n_bytes == 0) begin
            queue_word(8'h00, 1'b0, st, 1'b1);
        end else begin
            for (k = 0; k < n_bytes; k++) queue_word(seq[k], 1'b1, st, k == n_bytes - 1);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_decoded_word want;
        t_decoded_word got;
        if (!i_rst_n) begin
            parse_phase = PH_IDLE;
            in_double   = 1'b0;
            json_mode   = 1'b0;
            hex_word    = '0;
            hex_count   = '0;
            high_half   = '0;
            expected_words.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                decode_word(i_in.in_byte, i_in.start_of_string, i_in.json_rules,
                            i_in.end_of_range);
            end
            if (i_out.valid && i_out.ready) begin
                got = {i_out.out_byte, i_out.byte_valid, i_out.status, i_out.last};
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("%0t unexpected word: byte=%02h bv=%0d st=%0d last=%0d",
                                 $time, got.data, got.has_byte, got.status, got.last);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN) begin
                            $display({"%0t mismatch: want byte=%02h bv=%0d st=%0d last=%0d,",
                                      " got byte=%02h bv=%0d st=%0d last=%0d"}, $time,
                                     want.data, want.has_byte, want.status, want.last,
                                     got.data, got.has_byte, got.status, got.last);
                        end
                    end
                end
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= expected_words.size();
    end

endmodule

// ===== sim/quoted_string_unescape_top_tb.sv =====
module quoted_string_unescape_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0]  CH_DQUOTE    = 8'h22;
    localparam logic [7:0]  CH_SQUOTE    = 8'h27;
    localparam logic [7:0]  CH_BSLASH    = 8'h5c;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [15:0] HI_SUR_MIN   = 16'hd800;
    localparam logic [15:0] LO_SUR_MIN   = 16'hdc00;
    // the eight single-letter escapes, one per byte
    localparam logic [63:0] ESC_LETTERS  = "btnfr\"/\\";
    localparam int          RANDOM_WORDS = 285;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   send_idle_pct = 24;
    int   recv_idle_pct = 85;
    int   words_sent    = 0;
    int   hold_requests = 0;
    int   holds_done    = 0;

    qsu_in_if  in_ch ();
    qsu_out_if out_ch ();

    quoted_string_unescape_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // watches both channels, predicts every result word and compares
    qsu_unescape_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offer one source byte; insert random idle cycles first, then hold it until taken.
    // Valid stays high across back-to-back words so it never toggles within one step.
    task automatic send_word(input logic [7:0] c, input bit sos, input bit js,
                             input bit eor, input bit counted = 1'b1);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.in_byte         <= c;
        in_ch.start_of_string <= sos;
        in_ch.json_rules      <= js;
        in_ch.end_of_range    <= eor;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (counted) words_sent++;
    endtask

    // body byte: json_rules only matters on an opener, so toggle it freely here
    task automatic send_body(input logic [7:0] c, input bit eor = 1'b0);
        send_word(c, 1'b0, 1'($urandom_range(0, 1)), eor);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_body(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + n;
        return ($urandom_range(0, 1) ? "A" : "a") + n - 8'd10;
    endfunction

    task automatic send_u_escape(input logic [15:0] v);
        int k;
        send_body(CH_BSLASH);
        send_body("u");
        for (k = 3; k >= 0; k--) send_body(hex_char(v[k*4 +: 4]));
    endtask

    // low ten bits of a surrogate, leaning toward the ends of the range
    function automatic logic [15:0] sur_bits();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'h03ff;
            default: return 16'($urandom_range(0, 16'h03ff));
        endcase
    endfunction

    // printable or high byte that neither closes the string nor starts an escape
    function automatic logic [7:0] plain_char(input bit dbl, input logic [7:0] quote);
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'hff));
        if (c == quote || (dbl && c == CH_BSLASH)) c = "a";
        return c;
    endfunction

    // Drop a sequence that usually kills the string: control byte, random escape letter, bad hex digit,
    // lone low surrogate, high surrogate without a following \u, or a bad low half; single quotes get the first.
    task automatic send_broken(input bit dbl);
        case ($urandom_range(0, dbl ? 6 : 0))
            0: send_word(8'($urandom_range(0, 8'h1f)), 1'b0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            1: begin
                send_body(CH_BSLASH);
                send_body(8'($urandom_range(8'h20, 8'h7e)));
            end
            2: send_text("\\u12g4");
            3: send_u_escape(LO_SUR_MIN | sur_bits());
            4: begin
                send_u_escape(HI_SUR_MIN | sur_bits());
                send_body("z");
            end
            5: begin
                send_u_escape(HI_SUR_MIN | sur_bits());
                send_text("\\x");
            end
            default: begin
                send_u_escape(HI_SUR_MIN | sur_bits());
                send_u_escape($urandom_range(0, 1) ? 16'hdbff : 16'($urandom_range(0, 16'hdbff)));
            end
        endcase
    endtask

    // One mostly well-formed string with random content and a random way of ending.
    task automatic send_random_string();
        bit          js;
        bit          dbl;
        logic [7:0]  quote;
        logic [15:0] cp;
        int          n_elem;
        int          pick;
        int          i;
        js    = 1'($urandom_range(0, 1));
        dbl   = js || 1'($urandom_range(0, 1));
        quote = dbl ? CH_DQUOTE : CH_SQUOTE;
        // an opener on the last byte of the range ends the string at once
        if ($urandom_range(0, 39) == 0) begin
            send_word(quote, 1'b1, js, 1'b1);
            return;
        end
        send_word(quote, 1'b1, js, 1'b0);

        n_elem = $urandom_range(0, 6);
        for (i = 0; i < n_elem; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || (!dbl && pick < 80)) begin
                send_body(plain_char(dbl, quote));
            end else if (pick < 58) begin
                send_body(CH_BSLASH);
                send_body(ESC_LETTERS[8*$urandom_range(0, 7) +: 8]);
            end else if (pick < 72) begin
                // one code point from a random UTF-8 length band of up to three bytes, surrogates excluded
                case ($urandom_range(0, 3))
                    0:       cp = 16'($urandom_range(0, 16'h7f));
                    1:       cp = 16'($urandom_range(16'h80, 16'h7ff));
                    2:       cp = 16'($urandom_range(16'h800, 16'hd7ff));
                    default: cp = 16'($urandom_range(16'he000, 16'hffff));
                endcase
                send_u_escape(cp);
            end else if (pick < 82) begin
                send_u_escape(HI_SUR_MIN | sur_bits());
                send_u_escape(LO_SUR_MIN | sur_bits());
            end else if (pick < 88) begin
                // raw tab is legal only outside strict mode
                if (!js) send_body(CH_TAB);
                else send_body(plain_char(dbl, quote));
            end else if (pick < 95 && !dbl) begin
                send_body(CH_SQUOTE);
                send_body(CH_SQUOTE);
            end else if (pick < 97) begin
                send_broken(dbl);
                return;
            end else begin
                send_body(plain_char(dbl, quote));
            end
        end

        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // range runs out in the body
            send_body(plain_char(dbl, quote), 1'b1);
        end else if (pick < 12 && dbl) begin
            send_body(CH_BSLASH, 1'b1);
        end else if (pick < 16 && dbl) begin
            send_text("\\ua");
            send_body("b", 1'b1);
        end else if (pick < 20 && dbl) begin
            send_u_escape(HI_SUR_MIN | sur_bits());
            send_body(CH_BSLASH, 1'b1);
        end else if (pick < 28) begin
            // leave it open: the next opener closes it
        end else begin
            send_body(quote, $urandom_range(0, 7) == 0);
            // a pending single quote resolves on the next byte, or on the next opener
            if (!dbl && $urandom_range(0, 2) == 0) send_body(plain_char(dbl, quote));
            if ($urandom_range(0, 4) == 0) begin
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'b0);
            end
        end
    endtask

    // raw bytes with random markers: bad openers, stray bytes, stray range ends
    task automatic send_noise();
        logic [7:0] c;
        int         n;
        n = $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       c = CH_DQUOTE;
                1:       c = CH_SQUOTE;
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_word(c, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 7) == 0);
        end
    endtask

    // Receiver: random backpressure, plus a long hold-off when asked for one.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.in_byte         <= 8'h00;
        in_ch.start_of_string <= 1'b0;
        in_ch.json_rules      <= 1'b0;
        in_ch.end_of_range    <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        // Stray byte with nothing open: no result.
        send_word(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        // Strict double-quoted string: high byte, \n, a surrogate pair to four bytes, close.
        send_word(CH_DQUOTE, 1'b1, 1'b1, 1'b0);
        send_body(8'hff);
        send_text("\\n\\ud83d\\uDE00\"");
        // Lenient single-quoted string: raw tab, two doubled quotes and a plain byte, left open
        // so that the next opener ends it as unterminated.
        send_word(CH_SQUOTE, 1'b1, 1'b0, 1'b0);
        send_body(CH_TAB);
        send_text("''''z");
        // Opener on the last byte of the range, then a bad opener at the range end.
        send_word(CH_DQUOTE, 1'b1, 1'b0, 1'b1);
        send_word(8'hff, 1'b1, 1'b1, 1'b1);

        // Random part, in three idling profiles.
        words_sent = 0;
        while (words_sent < RANDOM_WORDS / 3) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_random_string();
        end
        send_idle_pct = 85;
        recv_idle_pct = 24;
        while (words_sent < 2 * RANDOM_WORDS / 3) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_random_string();
        end
        // No idling; hold the receiver off for a while so the block backs up its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_random_string();
        end
        in_ch.valid <= 1'b0;

        // Drain: wait for every expected word, then watch a little longer for extras.
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
